/* hw/rtl/vn_pkg.sv */
// ----------------------------------------------------------------------------
// vn_pkg: shared types and constants for the vector normaliser
// Widths of the intermediate values, pipeline step counts and sideband type.
// ----------------------------------------------------------------------------
package vn_pkg;

    localparam int COMP_W     = 16;              // input and output component width
    localparam int SQ_W       = 32;              // a square, at most 2^30
    localparam int DEN_W      = 32;              // x*x + y*y, at most 2^31
    localparam int FRAC_SH    = 30;              // the numerator is a*a scaled by 2^30
    localparam int NUM_W      = 61;              // a*a*2^30, at most 2^60
    localparam int QUO_W      = 31;              // quotient, at most 2^30
    localparam int ROOT_W     = 32;              // root and radicand working width
    localparam int DIV_STEPS  = QUO_W;           // one quotient bit per stage
    localparam int SQRT_STEPS = 16;              // one root bit per stage
    localparam int FRONT_LAT  = 3;
    localparam int LATENCY    = FRONT_LAT + DIV_STEPS + SQRT_STEPS + 1;

    localparam logic [COMP_W-1:0] UNIT_MAX = 16'h7FFF;

    // Travels beside each component through the divider and root pipelines.
    typedef struct packed {
        logic neg;
        logic zero;
    } t_side;

endpackage

/* hw/rtl/vn_front.sv */
// ----------------------------------------------------------------------------
// vn_front: magnitude, squares and sum of squares
// Three stages: absolute values, squares, then x*x + y*y and numerators.
// ----------------------------------------------------------------------------
module vn_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic signed [15:0]          i_vec_x,
    input  logic signed [15:0]          i_vec_y,
    output logic                        o_valid,
    output logic [vn_pkg::NUM_W-1:0]    o_num_x,
    output logic [vn_pkg::NUM_W-1:0]    o_num_y,
    output logic [vn_pkg::DEN_W-1:0]    o_den,
    output vn_pkg::t_side               o_side_x,
    output vn_pkg::t_side               o_side_y
);
    import vn_pkg::*;

    logic              r_v1, r_v2, r_v3;
    logic [COMP_W-1:0] r_ax, r_ay;
    logic              r_nx1, r_ny1, r_nx2, r_ny2;
    logic [SQ_W-1:0]   r_sqx, r_sqy;
    logic [NUM_W-1:0]  r_numx, r_numy;
    logic [DEN_W-1:0]  r_den;
    t_side             r_sx, r_sy;
    logic [COMP_W-1:0] n_ax, n_ay;
    logic [DEN_W-1:0]  n_den;

    // The negation of -32768 wraps to 0x8000, which read unsigned is 32768.
    assign n_ax  = i_vec_x[COMP_W-1] ? COMP_W'(-i_vec_x) : COMP_W'(i_vec_x);
    assign n_ay  = i_vec_y[COMP_W-1] ? COMP_W'(-i_vec_y) : COMP_W'(i_vec_y);
    assign n_den = r_sqx + r_sqy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ax   <= n_ax;
            r_ay   <= n_ay;
            r_nx1  <= i_vec_x[COMP_W-1];
            r_ny1  <= i_vec_y[COMP_W-1];
            r_sqx  <= r_ax * r_ax;
            r_sqy  <= r_ay * r_ay;
            r_nx2  <= r_nx1;
            r_ny2  <= r_ny1;
            r_den  <= n_den;
            r_numx <= {r_sqx[NUM_W-FRAC_SH-1:0], {FRAC_SH{1'b0}}};
            r_numy <= {r_sqy[NUM_W-FRAC_SH-1:0], {FRAC_SH{1'b0}}};
            r_sx   <= '{neg: r_nx2, zero: (n_den == '0)};
            r_sy   <= '{neg: r_ny2, zero: (n_den == '0)};
        end
    end

    assign o_valid  = r_v3;
    assign o_num_x  = r_numx;
    assign o_num_y  = r_numy;
    assign o_den    = r_den;
    assign o_side_x = r_sx;
    assign o_side_y = r_sy;

endmodule

/* hw/rtl/vn_divider.sv */
// ----------------------------------------------------------------------------
// vn_divider: pipelined restoring divider
// One quotient bit per stage, most significant first, over 31 stages.
// ----------------------------------------------------------------------------
module vn_divider (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [vn_pkg::NUM_W-1:0]    i_num,
    input  logic [vn_pkg::DEN_W-1:0]    i_den,
    input  vn_pkg::t_side               i_side,
    output logic                        o_valid,
    output logic [vn_pkg::QUO_W-1:0]    o_quot,
    output vn_pkg::t_side               o_side
);
    import vn_pkg::*;

    logic             w_v    [0:DIV_STEPS];
    logic [QUO_W-1:0] w_quo  [0:DIV_STEPS];
    t_side            w_side [0:DIV_STEPS];
    logic [NUM_W-1:0] w_rem  [0:DIV_STEPS-1];
    logic [DEN_W-1:0] w_den  [0:DIV_STEPS-1];

    assign w_v[0]    = i_valid;
    assign w_quo[0]  = '0;
    assign w_side[0] = i_side;
    assign w_rem[0]  = i_num;
    assign w_den[0]  = i_den;

    for (genvar s = 0; s < DIV_STEPS; s++) begin : g_step
        localparam int SH = DIV_STEPS - 1 - s;
        logic [NUM_W:0]   w_dsh;
        logic [NUM_W:0]   w_diff;
        logic             w_ge;
        logic             r_v;
        logic [QUO_W-1:0] r_quo;
        t_side            r_side;

        assign w_dsh  = {{(NUM_W + 1 - DEN_W){1'b0}}, w_den[s]} << SH;
        assign w_diff = {1'b0, w_rem[s]} - w_dsh;
        assign w_ge   = ({1'b0, w_rem[s]} >= w_dsh);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (i_en) begin
                r_v <= w_v[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_quo  <= {w_quo[s][QUO_W-2:0], w_ge};
                r_side <= w_side[s];
            end
        end

        assign w_v[s+1]    = r_v;
        assign w_quo[s+1]  = r_quo;
        assign w_side[s+1] = r_side;

        if (s < DIV_STEPS - 1) begin : g_carry
            logic [NUM_W-1:0] r_rem;
            logic [DEN_W-1:0] r_den;

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem <= w_ge ? w_diff[NUM_W-1:0] : w_rem[s];
                    r_den <= w_den[s];
                end
            end

            assign w_rem[s+1] = r_rem;
            assign w_den[s+1] = r_den;
        end
    end

    assign o_valid = w_v[DIV_STEPS];
    assign o_quot  = w_quo[DIV_STEPS];
    assign o_side  = w_side[DIV_STEPS];

endmodule

/* hw/rtl/vn_sqrt.sv */
// ----------------------------------------------------------------------------
// vn_sqrt: pipelined integer square root
// Bit-serial floor root, one result bit per stage, over 16 stages.
// ----------------------------------------------------------------------------
module vn_sqrt (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [vn_pkg::QUO_W-1:0]    i_rad,
    input  vn_pkg::t_side               i_side,
    output logic                        o_valid,
    output logic [vn_pkg::ROOT_W-1:0]   o_root,
    output vn_pkg::t_side               o_side
);
    import vn_pkg::*;

    logic              w_v    [0:SQRT_STEPS];
    logic [ROOT_W-1:0] w_root [0:SQRT_STEPS];
    t_side             w_side [0:SQRT_STEPS];
    logic [ROOT_W-1:0] w_rad  [0:SQRT_STEPS-1];

    assign w_v[0]    = i_valid;
    assign w_root[0] = '0;
    assign w_side[0] = i_side;
    assign w_rad[0]  = ROOT_W'(i_rad);

    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
        localparam logic [ROOT_W-1:0] BIT = ROOT_W'(1) << (2 * (SQRT_STEPS - 1 - k));
        logic [ROOT_W-1:0] w_trial;
        logic              w_ge;
        logic              r_v;
        logic [ROOT_W-1:0] r_root;
        t_side             r_side;

        assign w_trial = w_root[k] + BIT;
        assign w_ge    = (w_rad[k] >= w_trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (i_en) begin
                r_v <= w_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_root <= w_ge ? ((w_root[k] >> 1) + BIT) : (w_root[k] >> 1);
                r_side <= w_side[k];
            end
        end

        assign w_v[k+1]    = r_v;
        assign w_root[k+1] = r_root;
        assign w_side[k+1] = r_side;

        if (k < SQRT_STEPS - 1) begin : g_carry
            logic [ROOT_W-1:0] r_rad;

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rad <= w_ge ? (w_rad[k] - w_trial) : w_rad[k];
                end
            end

            assign w_rad[k+1] = r_rad;
        end
    end

    assign o_valid = w_v[SQRT_STEPS];
    assign o_root  = w_root[SQRT_STEPS];
    assign o_side  = w_side[SQRT_STEPS];

endmodule

/* hw/rtl/vector2_normalize.sv */
// ----------------------------------------------------------------------------
// vector2_normalize: fixed-point 2D vector normaliser
// Returns the Q1.15 unit vector of a signed 16-bit vector.
// ----------------------------------------------------------------------------
// Usage
// The input channel takes one vector per transaction on i_vec_x and i_vec_y
// (i_valid, o_stall); the output channel gives o_unit_x, o_unit_y and
// o_was_zero (o_valid, i_stall). Each component is the floor of the root of
// the floored quotient c*c*2^30 / (x*x + y*y), saturated to 32767 and given
// the sign of c. A zero vector gives zero components with o_was_zero set.
// From accepted input to valid output a transaction passes three front
// stages, 31 divider stages with one quotient bit each, 16 root stages with
// one root bit each, and the output register. Throughput is one transaction
// per cycle unless the output stalls; both components run in parallel lanes.
// Reset clears every valid bit and holds o_stall high while it is asserted;
// the block accepts input in the first cycle after reset. When the receiver
// stalls a valid output the whole pipeline holds and o_stall is raised in the
// same cycle, so no transaction is lost or repeated.
// ----------------------------------------------------------------------------
module vector2_normalize (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic signed [15:0]   i_vec_x,
    input  logic signed [15:0]   i_vec_y,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic signed [15:0]   o_unit_x,
    output logic signed [15:0]   o_unit_y,
    output logic                 o_was_zero
);
    import vn_pkg::*;

    logic              w_en;
    logic              w_fr_v;
    logic [NUM_W-1:0]  w_num_x, w_num_y;
    logic [DEN_W-1:0]  w_den;
    t_side             w_fs_x, w_fs_y, w_ds_x, w_ds_y, w_rs_x, w_rs_y;
    logic              w_dv_x, w_dv_y, w_rv_x, w_rv_y;
    logic [QUO_W-1:0]  w_q_x, w_q_y;
    logic [ROOT_W-1:0] w_root_x, w_root_y;
    logic [COMP_W-1:0] n_ux, n_uy;
    logic              r_out_v;
    logic [COMP_W-1:0] r_ux, r_uy;
    logic              r_zero;

    assign w_en = ~(r_out_v & i_stall);

    vn_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (i_valid),
        .i_vec_x  (i_vec_x),
        .i_vec_y  (i_vec_y),
        .o_valid  (w_fr_v),
        .o_num_x  (w_num_x),
        .o_num_y  (w_num_y),
        .o_den    (w_den),
        .o_side_x (w_fs_x),
        .o_side_y (w_fs_y)
    );

    vn_divider u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_fr_v),
        .i_num   (w_num_x),
        .i_den   (w_den),
        .i_side  (w_fs_x),
        .o_valid (w_dv_x),
        .o_quot  (w_q_x),
        .o_side  (w_ds_x)
    );

    vn_divider u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_fr_v),
        .i_num   (w_num_y),
        .i_den   (w_den),
        .i_side  (w_fs_y),
        .o_valid (w_dv_y),
        .o_quot  (w_q_y),
        .o_side  (w_ds_y)
    );

    vn_sqrt u_sqrt_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_dv_x),
        .i_rad   (w_q_x),
        .i_side  (w_ds_x),
        .o_valid (w_rv_x),
        .o_root  (w_root_x),
        .o_side  (w_rs_x)
    );

    vn_sqrt u_sqrt_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_dv_y),
        .i_rad   (w_q_y),
        .i_side  (w_ds_y),
        .o_valid (w_rv_y),
        .o_root  (w_root_y),
        .o_side  (w_rs_y)
    );

    // A divide by zero leaves junk in the lanes, so the zero flag masks it here.
    always_comb begin
        n_ux = (w_root_x > ROOT_W'(UNIT_MAX)) ? UNIT_MAX : w_root_x[COMP_W-1:0];
        n_uy = (w_root_y > ROOT_W'(UNIT_MAX)) ? UNIT_MAX : w_root_y[COMP_W-1:0];
        if (w_rs_x.neg) begin
            n_ux = -n_ux;
        end
        if (w_rs_y.neg) begin
            n_uy = -n_uy;
        end
        if (w_rs_x.zero) begin
            n_ux = '0;
            n_uy = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_en) begin
            r_out_v <= w_rv_x & w_rv_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ux   <= n_ux;
            r_uy   <= n_uy;
            r_zero <= w_rs_y.zero;
        end
    end

    assign o_stall    = ~w_en | ~i_rst_n;
    assign o_valid    = r_out_v & i_rst_n;
    assign o_unit_x   = r_ux;
    assign o_unit_y   = r_uy;
    assign o_was_zero = r_zero;

endmodule

/* hw/rtl/vn_checker.sv */
// ----------------------------------------------------------------------------
// vn_checker: port-level checks for the vector normaliser
// Watches the top-level ports and is bound to every instance of it.
// ----------------------------------------------------------------------------
module vn_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_valid,
    input logic                o_stall,
    input logic signed [15:0]  i_vec_x,
    input logic signed [15:0]  i_vec_y,
    input logic                o_valid,
    input logic                i_stall,
    input logic signed [15:0]  o_unit_x,
    input logic signed [15:0]  o_unit_y,
    input logic                o_was_zero
);

    // Reset empties the pipeline, so nothing is offered in the next cycle.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid straight after reset");

    // The input side only stalls because a finished result is being held.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without a held output");

    // A zero vector must give zero components.
    a_zero_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_was_zero) |-> (o_unit_x == 16'sd0 && o_unit_y == 16'sd0))
        else $error("zero vector gave nonzero components");

    // Saturation keeps the components symmetric about zero.
    a_no_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_unit_x != 16'sh8000 && o_unit_y != 16'sh8000))
        else $error("component reached the most negative code");

    // A held result keeps its payload.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_unit_x) && $stable(o_unit_y)
                                  && $stable(o_was_zero)))
        else $error("held output changed");

endmodule

bind vector2_normalize vn_checker u_vn_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_valid    (i_valid),
    .o_stall    (o_stall),
    .i_vec_x    (i_vec_x),
    .i_vec_y    (i_vec_y),
    .o_valid    (o_valid),
    .i_stall    (i_stall),
    .o_unit_x   (o_unit_x),
    .o_unit_y   (o_unit_y),
    .o_was_zero (o_was_zero)
);

/* test/vector2_normalize_checker.sv */
// ----------------------------------------------------------------------------
// vector2_normalize_checker: result predictor and comparator
// Watches both channels of the normaliser, computes the expected unit vector
// for every accepted input transaction and compares each output transaction
// field by field with the oldest expected one.
// ----------------------------------------------------------------------------
module vector2_normalize_checker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic                 o_stall,
    input  logic signed [15:0]   i_vec_x,
    input  logic signed [15:0]   i_vec_y,
    input  logic                 o_valid,
    input  logic                 i_stall,
    input  logic signed [15:0]   o_unit_x,
    input  logic signed [15:0]   o_unit_y,
    input  logic                 o_was_zero,
    output int                   o_errors,
    output int                   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [15:0] ux;
        logic [15:0] uy;
        logic        zero;
    } t_unit;

    t_unit unit_queue[$];
    int    err_count = 0;

    assign o_errors  = err_count;
    assign o_pending = unit_queue.size();

    function automatic logic [63:0] floor_root(logic [63:0] v);
        logic [63:0] root;
        logic [63:0] bitpos;
        root   = 0;
        bitpos = 64'd1 << 62;
        while (bitpos > v) bitpos = bitpos >> 2;
        while (bitpos != 0) begin
            if (v >= root + bitpos) begin
                v    = v - (root + bitpos);
                root = (root >> 1) + bitpos;
            end else begin
                root = root >> 1;
            end
            bitpos = bitpos >> 2;
        end
        return root;
    endfunction

    function automatic logic [15:0] unit_comp(logic signed [15:0] c, logic [63:0] mag2);
        logic [63:0] a;
        logic [63:0] r;
        a = (c < 0) ? 64'(-32'(c)) : 64'(c);
        r = floor_root(((a * a) << 30) / mag2);
        if (r > 64'd32767) r = 64'd32767;
        if (c < 0) r = -r;
        return r[15:0];
    endfunction

    function automatic t_unit normalise(logic signed [15:0] x, logic signed [15:0] y);
        t_unit       u;
        logic [63:0] ax;
        logic [63:0] ay;
        logic [63:0] mag2;
        ax   = (x < 0) ? 64'(-32'(x)) : 64'(x);
        ay   = (y < 0) ? 64'(-32'(y)) : 64'(y);
        mag2 = ax * ax + ay * ay;
        if (mag2 == 0) begin
            u = '{ux: '0, uy: '0, zero: 1'b1};
        end else begin
            u = '{ux: unit_comp(x, mag2), uy: unit_comp(y, mag2), zero: 1'b0};
        end
        return u;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $time);
        err_count++;
    endtask

    always @(posedge i_clk) begin
        t_unit want;
        if (i_rst_n) begin
            if (i_valid && !o_stall) unit_queue.push_back(normalise(i_vec_x, i_vec_y));
            if (o_valid && !i_stall) begin
                if (unit_queue.size() == 0) begin
                    report_mismatch("unexpected transaction", 1, 0);
                end else begin
                    want = unit_queue.pop_front();
                    if (o_unit_x !== want.ux)
                        report_mismatch("unit_x", o_unit_x, $signed(want.ux));
                    if (o_unit_y !== want.uy)
                        report_mismatch("unit_y", o_unit_y, $signed(want.uy));
                    if (o_was_zero !== want.zero)
                        report_mismatch("was_zero", o_was_zero, want.zero);
                end
            end
        end
    end

endmodule

/* test/tb_vector2_normalize.sv */
// ----------------------------------------------------------------------------
// tb_vector2_normalize: testbench for the vector normaliser
// Drives directed corner vectors and then random ones, with random gaps and
// receiver stalls, a long receiver hold-off and a drain pause; the checker
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_vector2_normalize;
    timeunit 1ns;
    timeprecision 1ps;

    import vn_pkg::*;

    localparam int N_RANDOM    = 1880;
    localparam int CYCLE_LIMIT = 200000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic signed [15:0] i_vec_x = '0;
    logic signed [15:0] i_vec_y = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic signed [15:0] o_unit_x;
    logic signed [15:0] o_unit_y;
    logic               o_was_zero;
    int                 errors;
    int                 pending;
    int                 cycles = 0;
    logic               calm = 1'b0;
    logic               hold_off = 1'b0;

    vector2_normalize uut (.*);

    vector2_normalize_checker checker_i (.*, .o_errors(errors), .o_pending(pending));

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("[vector2_normalize] ERROR");
            $finish;
        end
    end

    // Receiver: random stalls, none during the calm stretch, solid during hold-off.
    always @(posedge i_clk) begin
        if (!i_rst_n) i_stall <= 1'b0;
        else i_stall <= hold_off || (!calm && $urandom_range(99) < 8);
    end

    task automatic send_vector(logic signed [15:0] x, logic signed [15:0] y);
        while (!calm && $urandom_range(99) < 8) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_vec_x <= x;
        i_vec_y <= y;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    function automatic logic signed [15:0] rand_comp();
        case ($urandom_range(5))
            0: return 16'($urandom_range(7)) - 16'sd4;
            1: return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
            2: return 16'($urandom_range(255)) - 16'sd128;
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        logic signed [15:0] corner [9] = '{16'sd0, 16'sd1, -16'sd1, 16'sh7FFF,
            16'sh8000, 16'sd3, -16'sd4, 16'sh4000, -16'sd12345};
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // Zero vector, axis-aligned full scale, most negative input, mixed signs.
        for (int i = 0; i < 5; i++)
            for (int j = 0; j < 5; j++) send_vector(corner[i * 2 % 9], corner[j + i % 4]);
        i_valid <= 1'b0;
        // Pause until every expected result has come.
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        // Long hold-off of the receiver while the sender keeps offering.
        fork
            begin
                hold_off <= 1'b1;
                repeat (150) @(posedge i_clk);
                hold_off <= 1'b0;
            end
            for (int k = 0; k < 120; k++) send_vector(rand_comp(), rand_comp());
        join
        for (int k = 0; k < N_RANDOM - 120; k++) begin
            calm <= (k >= 600 && k < 900);
            send_vector(rand_comp(), rand_comp());
        end
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (errors == 0) begin
            $display("[vector2_normalize] OK");
        end else begin
            $display("[vector2_normalize] ERROR");
        end
        $finish;
    end

endmodule
